@@ design/rgb3x3_pkg.sv @@
package rgb3x3_pkg;

    localparam int MaxWidth  = 2048;
    localparam int MaxHeight = 4095;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = 12;
    localparam int CfgW      = 12;

    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_WIDTH     = 2'd2;
    localparam logic [1:0] CFG_HEIGHT    = 2'd3;

    localparam logic [2:0] MODE_BLUR    = 3'd0;
    localparam logic [2:0] MODE_EMBOSS  = 3'd1;
    localparam logic [2:0] MODE_SHARPEN = 3'd2;
    localparam logic [2:0] MODE_SOBEL   = 3'd3;
    localparam logic [2:0] MODE_COLOUR  = 3'd4;

    localparam logic [16:0] GREY_R = 17'd19595;
    localparam logic [16:0] GREY_G = 17'd38470;
    localparam logic [16:0] GREY_B = 17'd7471;

    typedef logic [23:0] pix_t;
    typedef logic [7:0]  chan_t;

    function automatic chan_t sat8(input logic signed [12:0] v);
        chan_t r;
        if (v < 13'sd0)
            r = 8'd0;
        else if (v > 13'sd255)
            r = 8'd255;
        else
            r = v[7:0];
        return r;
    endfunction

    // lowest and highest set bits of a four-slot mask
    function automatic logic [1:0] first_slot(input logic [3:0] m);
        logic [1:0] r;
        r = 2'd3;
        if (m[2]) r = 2'd2;
        if (m[1]) r = 2'd1;
        if (m[0]) r = 2'd0;
        return r;
    endfunction

    function automatic logic [1:0] last_slot(input logic [3:0] m);
        logic [1:0] r;
        r = 2'd0;
        if (m[1]) r = 2'd1;
        if (m[2]) r = 2'd2;
        if (m[3]) r = 2'd3;
        return r;
    endfunction

endpackage

@@ design/rgb_3x3_convolution_filter_top.sv @@
// Channel   Handshake              Payload
// config    cfg_we                 cfg_index, cfg_data
// input     in_valid / in_stall    red_in, green_in, blue_in
// output    out_valid / out_stall  red_out, green_out, blue_out, out_column,
//                                  out_row, last_of_run, frame_done
//
// One item at a time: the line stores are read and updated, then each of
// up to four results is computed (blur, emboss, sharpen directly, or Sobel
// through the square-root loop: one square-root bit per cycle, eleven bits)
// and waits on out_stall; the end of a row adds a step that repeats the
// right-hand column. Reset clears window, position and registers; the line
// stores are not cleared and are only read where the frame wrote them.
module rgb_3x3_convolution_filter_top
    import rgb3x3_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [CfgW-1:0] cfg_data,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      red_in,
    input  logic [7:0]      green_in,
    input  logic [7:0]      blue_in,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      red_out,
    output logic [7:0]      green_out,
    output logic [7:0]      blue_out,
    output logic [ColW-1:0] out_column,
    output logic [RowW-1:0] out_row,
    output logic            last_of_run,
    output logic            frame_done
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_CALC = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_GREY = 3'd5;
    localparam logic [2:0] S_SUM  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    // configuration
    logic [2:0]      mode_reg;
    logic [7:0]      thr_reg;
    logic [CfgW-1:0] fw_reg;
    logic [CfgW-1:0] fh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BLUR;
            thr_reg  <= 8'd100;
            fw_reg   <= 12'd640;
            fh_reg   <= 12'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:      mode_reg <= cfg_data[2:0];
                CFG_THRESHOLD: thr_reg  <= cfg_data[7:0];
                CFG_WIDTH:     fw_reg   <= cfg_data;
                CFG_HEIGHT:    fh_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // saturate the frame size; compare against last index
    logic [CfgW-1:0] w_last, h_last;
    always_comb
    begin
        if (fw_reg > CfgW'(MaxWidth))
            w_last = CfgW'(MaxWidth - 1);
        else if (fw_reg < 12'd2)
            w_last = 12'd1;
        else
            w_last = fw_reg - 12'd1;
        if (fh_reg > CfgW'(MaxHeight))
            h_last = CfgW'(MaxHeight - 1);
        else if (fh_reg < 12'd2)
            h_last = 12'd1;
        else
            h_last = fh_reg - 12'd1;
    end

    logic [2:0]      state_reg;
    logic [ColW-1:0] col_reg;
    logic [RowW-1:0] row_reg;
    logic [ColW-1:0] c_q_reg;
    logic [RowW-1:0] r_q_reg;
    pix_t            pix_reg;
    logic [3:0]      pend_reg;
    logic [1:0]      slot_reg;
    logic [1:0]      lastslot_reg;
    logic            shift_reg;
    logic            lc_reg, lr_reg;
    pix_t            wp_reg [0:8];

    // line stores, registered read
    pix_t older_mem [0:MaxWidth-1];
    pix_t newer_mem [0:MaxWidth-1];
    pix_t older_q, newer_q;

    logic accept_in;
    assign accept_in = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            older_q <= older_mem[col_reg];
            newer_q <= newer_mem[col_reg];
        end
        if (state_reg == S_READ)
        begin
            if (r_q_reg >= 12'd1)
                older_mem[c_q_reg] <= newer_q;
            newer_mem[c_q_reg] <= pix_reg;
        end
    end

    // neighbourhood of the current slot: rows 0,1,2 or 1,2,2 (bottom clamp)
    pix_t q [0:8];
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (slot_reg[0])
            begin
                q[j]     = wp_reg[3 + j];
                q[3 + j] = wp_reg[6 + j];
            end
            else
            begin
                q[j]     = wp_reg[j];
                q[3 + j] = wp_reg[3 + j];
            end
            q[6 + j] = wp_reg[6 + j];
        end
    end

    // per-channel filters
    logic [2:0]             eff_mode;
    chan_t                  plain_res [0:2];
    logic signed [10:0]     gx [0:2];
    logic signed [10:0]     gy [0:2];

    always_comb
    begin
        logic [9:0]         bsum;
        logic signed [12:0] sh, em;
        logic [10:0]        a, b;
        eff_mode = mode_reg;
        if (mode_reg == MODE_COLOUR)
            eff_mode = (q[4][23:16] < thr_reg) ? MODE_BLUR : MODE_SHARPEN;
        for (int s = 0; s < 3; s++)
        begin
            bsum = 10'(q[0][23-8*s -: 4]) + 10'(q[2][23-8*s -: 4])
                 + 10'(q[6][23-8*s -: 4]) + 10'(q[8][23-8*s -: 4])
                 + 10'(q[1][23-8*s -: 5]) + 10'(q[3][23-8*s -: 5])
                 + 10'(q[5][23-8*s -: 5]) + 10'(q[7][23-8*s -: 5])
                 + 10'(q[4][23-8*s -: 6]);
            sh = 13'sd9 * $signed({5'd0, q[4][23-8*s -: 8]})
               - $signed({5'd0, q[0][23-8*s -: 8]}) - $signed({5'd0, q[1][23-8*s -: 8]})
               - $signed({5'd0, q[2][23-8*s -: 8]}) - $signed({5'd0, q[3][23-8*s -: 8]})
               - $signed({5'd0, q[5][23-8*s -: 8]}) - $signed({5'd0, q[6][23-8*s -: 8]})
               - $signed({5'd0, q[7][23-8*s -: 8]}) - $signed({5'd0, q[8][23-8*s -: 8]});
            em = 13'sd2 * $signed({5'd0, q[0][23-8*s -: 8]})
               - $signed({5'd0, q[4][23-8*s -: 8]}) - $signed({5'd0, q[8][23-8*s -: 8]});
            case (eff_mode)
                MODE_EMBOSS:  plain_res[s] = sat8(em);
                MODE_SHARPEN: plain_res[s] = sat8(sh);
                default:      plain_res[s] = sat8($signed({3'd0, bsum}));
            endcase
            a = 11'(q[2][23-8*s -: 8]) + {2'd0, q[5][23-8*s -: 8], 1'b0}
              + 11'(q[8][23-8*s -: 8]);
            b = 11'(q[0][23-8*s -: 8]) + {2'd0, q[3][23-8*s -: 8], 1'b0}
              + 11'(q[6][23-8*s -: 8]);
            gx[s] = $signed(a) - $signed(b);
            a = 11'(q[6][23-8*s -: 8]) + {2'd0, q[7][23-8*s -: 8], 1'b0}
              + 11'(q[8][23-8*s -: 8]);
            b = 11'(q[0][23-8*s -: 8]) + {2'd0, q[1][23-8*s -: 8], 1'b0}
              + 11'(q[2][23-8*s -: 8]);
            gy[s] = $signed(a) - $signed(b);
        end
    end

    // Sobel datapath registers
    logic signed [10:0] gx_reg [0:2];
    logic signed [10:0] gy_reg [0:2];
    logic [20:0]        v_reg  [0:2];
    logic [21:0]        res_sq_reg [0:2];
    logic [20:0]        bit_reg;
    logic [3:0]         step_reg;
    logic [23:0]        prod_reg [0:2];
    chan_t              res_reg  [0:2];

    // entry to the next slot of the run
    logic [3:0] pend_left;
    assign pend_left = pend_reg & ~(4'd1 << slot_reg);

    logic [3:0] mask_new;
    logic       lc_new, lr_new;
    always_comb
    begin
        lc_new      = {1'b0, c_q_reg} >= w_last;
        lr_new      = r_q_reg >= h_last;
        mask_new[0] = (r_q_reg >= 12'd1) && (c_q_reg >= 11'd1);
        mask_new[1] = mask_new[0] && lr_new;
        mask_new[2] = (r_q_reg >= 12'd1) && lc_new;
        mask_new[3] = mask_new[2] && lr_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            c_q_reg   <= '0;
            r_q_reg   <= '0;
            pix_reg   <= '0;
            pend_reg  <= '0;
            slot_reg  <= '0;
            lastslot_reg <= '0;
            shift_reg <= 1'b0;
            lc_reg    <= 1'b0;
            lr_reg    <= 1'b0;
            step_reg  <= '0;
            bit_reg   <= '0;
            for (int i = 0; i < 9; i++)
                wp_reg[i] <= '0;
            for (int s = 0; s < 3; s++)
            begin
                gx_reg[s]     <= '0;
                gy_reg[s]     <= '0;
                v_reg[s]      <= '0;
                res_sq_reg[s] <= '0;
                prod_reg[s]   <= '0;
                res_reg[s]    <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept_in)
                    begin
                        c_q_reg   <= col_reg;
                        r_q_reg   <= row_reg;
                        pix_reg   <= {red_in, green_in, blue_in};
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    // load the window from the stores and the new item
                    pix_t mid, top;
                    mid = (r_q_reg >= 12'd1) ? newer_q : pix_reg;
                    top = (r_q_reg >= 12'd2) ? older_q : mid;
                    if (c_q_reg == '0)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            wp_reg[i]     <= top;
                            wp_reg[3 + i] <= mid;
                            wp_reg[6 + i] <= pix_reg;
                        end
                    end
                    else
                    begin
                        wp_reg[0] <= wp_reg[1]; wp_reg[1] <= wp_reg[2]; wp_reg[2] <= top;
                        wp_reg[3] <= wp_reg[4]; wp_reg[4] <= wp_reg[5]; wp_reg[5] <= mid;
                        wp_reg[6] <= wp_reg[7]; wp_reg[7] <= wp_reg[8]; wp_reg[8] <= pix_reg;
                    end
                    if (lc_new)
                    begin
                        col_reg <= '0;
                        row_reg <= lr_new ? '0 : r_q_reg + 12'd1;
                    end
                    else
                        col_reg <= c_q_reg + 11'd1;
                    lc_reg       <= lc_new;
                    lr_reg       <= lr_new;
                    pend_reg     <= mask_new;
                    slot_reg     <= first_slot(mask_new);
                    lastslot_reg <= last_slot(mask_new);
                    shift_reg    <= 1'b1;
                    state_reg    <= (mask_new == '0) ? S_IDLE : S_CALC;
                end
                S_CALC:
                begin
                    if (slot_reg[1] && shift_reg)
                    begin
                        // end of row: repeat the right-hand column once
                        shift_reg <= 1'b0;
                        wp_reg[0] <= wp_reg[1]; wp_reg[1] <= wp_reg[2];
                        wp_reg[3] <= wp_reg[4]; wp_reg[4] <= wp_reg[5];
                        wp_reg[6] <= wp_reg[7]; wp_reg[7] <= wp_reg[8];
                    end
                    else if (eff_mode == MODE_SOBEL)
                    begin
                        for (int s = 0; s < 3; s++)
                        begin
                            gx_reg[s] <= gx[s];
                            gy_reg[s] <= gy[s];
                        end
                        state_reg <= S_SQ;
                    end
                    else
                    begin
                        for (int s = 0; s < 3; s++)
                            res_reg[s] <= plain_res[s];
                        state_reg <= S_OUT;
                    end
                end
                S_SQ:
                begin
                    for (int s = 0; s < 3; s++)
                    begin
                        v_reg[s] <= 21'(gx_reg[s] * gx_reg[s]) + 21'(gy_reg[s] * gy_reg[s]);
                        res_sq_reg[s] <= '0;
                    end
                    bit_reg   <= 21'd1 << 20;
                    step_reg  <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    // one result bit per cycle in each lane
                    for (int s = 0; s < 3; s++)
                    begin
                        if ({1'b0, v_reg[s]} >= res_sq_reg[s] + {1'b0, bit_reg})
                        begin
                            v_reg[s] <= 21'({1'b0, v_reg[s]} - res_sq_reg[s]
                                            - {1'b0, bit_reg});
                            res_sq_reg[s] <= (res_sq_reg[s] >> 1) + {1'b0, bit_reg};
                        end
                        else
                            res_sq_reg[s] <= res_sq_reg[s] >> 1;
                    end
                    bit_reg  <= bit_reg >> 2;
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd10)
                        state_reg <= S_GREY;
                end
                S_GREY:
                begin
                    chan_t m [0:2];
                    for (int s = 0; s < 3; s++)
                        m[s] = (res_sq_reg[s] > 22'd255) ? 8'd255 : res_sq_reg[s][7:0];
                    prod_reg[0] <= 24'(GREY_R * m[0]);
                    prod_reg[1] <= 24'(GREY_G * m[1]);
                    prod_reg[2] <= 24'(GREY_B * m[2]);
                    state_reg   <= S_SUM;
                end
                S_SUM:
                begin
                    logic [23:0] g;
                    g = prod_reg[0] + prod_reg[1] + prod_reg[2];
                    for (int s = 0; s < 3; s++)
                        res_reg[s] <= g[23:16];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        pend_reg <= pend_left;
                        slot_reg <= first_slot(pend_left);
                        state_reg <= (pend_left == '0) ? S_IDLE : S_CALC;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = (state_reg == S_OUT);
    assign red_out     = res_reg[0];
    assign green_out   = res_reg[1];
    assign blue_out    = res_reg[2];
    assign out_column  = slot_reg[1] ? c_q_reg : c_q_reg - 11'd1;
    assign out_row     = slot_reg[0] ? r_q_reg : r_q_reg - 12'd1;
    assign last_of_run = (slot_reg == lastslot_reg);
    assign frame_done  = last_of_run && lc_reg && lr_reg;

endmodule
